// ===== sv/windowed_min_cost_stop_dp_core_defines.svh =====
// Assertion macros shared by the checker of the stop-selection core.
`ifndef WINDOWED_MIN_COST_STOP_DP_CORE_DEFINES_SVH
`define WINDOWED_MIN_COST_STOP_DP_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define WMCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define WMCS_ASSERT_NEXT(lbl, cond, expect_next, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== sv/wmcs_pkg.sv =====
// Shared constants, types and helper functions of the stop-selection core.
`timescale 1ns / 1ps
package wmcs_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int GAP_W = 7;
    localparam int EXT_W = (CNT_W > GAP_W) ? CNT_W : GAP_W;
    localparam int STOP_W = 30;
    localparam int COST_W = 50;
    localparam int S_TDATA_W = ((STOP_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = ((COST_W + 7) / 8) * 8;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
    } result_t;

    // Clamps the configured gap into 1 .. WINDOW_DEPTH.
    function automatic logic [CNT_W-1:0] effective_gap(input logic [GAP_W-1:0] g);
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] lim;
        ext = EXT_W'(g);
        lim = EXT_W'(WINDOW_DEPTH);
        if (ext == '0) begin
            return CNT_W'(1);
        end else if (ext > lim) begin
            return CNT_W'(WINDOW_DEPTH);
        end
        return ext[CNT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
        if (a == '0) begin
            return ADDR_W'(WINDOW_DEPTH - 1);
        end
        return a - ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        if (a == ADDR_W'(WINDOW_DEPTH - 1)) begin
            return '0;
        end
        return a + ADDR_W'(1);
    endfunction

endpackage

// ===== sv/wmcs_window_ram.sv =====
// Candidate cost memory: one write port, one registered read port.
`timescale 1ns / 1ps
module wmcs_window_ram (
    input  logic                    aclk,
    input  wmcs_pkg::ram_wr_t       wr,
    input  logic                    rd_en,
    input  logic [wmcs_pkg::ADDR_W-1:0] rd_addr,
    output logic [wmcs_pkg::COST_W-1:0] rd_data
);
    import wmcs_pkg::*;

    logic [COST_W-1:0] mem [WINDOW_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/wmcs_ctrl.sv =====
// Sequencer: scans the candidate window (or seeds the origin on a new route), forms the result and writes it back.
`timescale 1ns / 1ps
module wmcs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [wmcs_pkg::STOP_W-1:0] in_stop_cost,
    input  logic                        in_mandatory,
    input  logic                        in_first,
    input  logic                        cfg_wr_en,
    input  logic [wmcs_pkg::GAP_W-1:0]  cfg_wr_data,
    input  logic                        out_free,
    output wmcs_pkg::result_t           res,
    output wmcs_pkg::ram_wr_t           ram_wr,
    output logic                        ram_rd_en,
    output logic [wmcs_pkg::ADDR_W-1:0] ram_rd_addr,
    input  logic [wmcs_pkg::COST_W-1:0] ram_rd_data
);
    import wmcs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_ORIGIN = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [GAP_W-1:0]        max_gap_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [ADDR_W-1:0]       wp_reg, wp_next;
    logic [ADDR_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pend_reg, pend_next;
    logic                    tag_reg, tag_next;
    logic [COST_W-1:0]       best_reg, best_next;
    logic                    found_reg, found_next;
    logic [STOP_W-1:0]       cost_reg;
    logic                    must_reg;
    logic [COST_W:0]         sum;
    logic [COST_W-1:0]       result_cost;
    logic [WINDOW_DEPTH-1:0] wp_bit;
    logic [WINDOW_DEPTH-1:0] rd_bit;

    assign in_ready    = (state_reg == ST_IDLE);
    assign ram_rd_en   = (state_reg == ST_SCAN);
    assign ram_rd_addr = rd_addr_reg;

    assign wp_bit = WINDOW_DEPTH'(1) << wp_reg;
    assign rd_bit = WINDOW_DEPTH'(1) << rd_addr_reg;

    assign sum = {1'b0, best_reg} + (COST_W + 1)'(cost_reg);
    assign result_cost = (!found_reg || sum > (COST_W + 1)'(COST_MAX)) ? COST_MAX
                                                                       : sum[COST_W-1:0];

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        wp_next      = wp_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        tag_next     = tag_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        ram_wr       = '0;
        res          = '0;

        // The read issued last cycle returns now; fold it into the minimum.
        if (pend_reg && tag_reg && (!found_reg || ram_rd_data < best_reg)) begin
            best_next  = ram_rd_data;
            found_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    rd_addr_next = addr_dec(wp_reg);
                    cnt_next     = effective_gap(max_gap_reg);
                    found_next   = 1'b0;
                    best_next    = COST_MAX;
                    state_next   = in_first ? ST_ORIGIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next    = 1'b1;
                tag_next     = valid_reg[rd_addr_reg];
                rd_addr_next = addr_dec(rd_addr_reg);
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_ORIGIN: begin
                // A new route: the origin at cost zero is the only candidate,
                // and no stored cost can beat it, so the scan is skipped.
                ram_wr.en   = 1'b1;
                ram_wr.addr = rd_addr_reg;
                ram_wr.data = '0;
                valid_next  = rd_bit;
                best_next   = '0;
                found_next  = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = wp_reg;
                    ram_wr.data = result_cost;
                    res.valid   = 1'b1;
                    res.cost    = result_cost;
                    valid_next  = must_reg ? wp_bit : (valid_reg | wp_bit);
                    wp_next     = addr_inc(wp_reg);
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            wp_reg      <= '0;
            pend_reg    <= 1'b0;
            max_gap_reg <= GAP_RESET;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            wp_reg    <= wp_next;
            pend_reg  <= pend_next;
            if (cfg_wr_en) begin
                max_gap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        cnt_reg     <= cnt_next;
        tag_reg     <= tag_next;
        best_reg    <= best_next;
        found_reg   <= found_next;
        if (in_valid && in_ready) begin
            cost_reg <= in_stop_cost;
            must_reg <= in_mandatory;
        end
    end

endmodule

// ===== sv/windowed_min_cost_stop_dp_core.sv =====
// Top level of the windowed minimum-cost stop-selection core.
// An item with first = 0 scans gap candidates before its result is formed; an item with
// first = 1 skips the scan. Here gap is max_gap clamped to 1 .. 64.
// Items are worked on one at a time: a new item is taken only after the last result is formed.
// The result register lets the next item enter while a result waits to be taken.
// Reset (aresetn low, synchronous) clears the window, the write pointer, max_gap to 1.
`timescale 1ns / 1ps
module windowed_min_cost_stop_dp_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wmcs_pkg::S_TDATA_W-1:0] s_tdata,   // stop_cost
    input  logic [wmcs_pkg::S_TUSER_W-1:0] s_tuser,   // mandatory, first
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wmcs_pkg::M_TDATA_W-1:0] m_tdata,   // best_cost
    input  logic                           cfg_wr_en,
    input  logic [wmcs_pkg::GAP_W-1:0]     cfg_wr_data
);
    import wmcs_pkg::*;

    result_t           res;
    ram_wr_t           ram_wr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [COST_W-1:0] ram_rd_data;
    logic              out_free;
    logic              out_valid_reg;
    logic [COST_W-1:0] out_cost_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_cost_reg);

    wmcs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_stop_cost (s_tdata[STOP_W-1:0]),
        .in_mandatory (s_tuser[0]),
        .in_first     (s_tuser[1]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_free     (out_free),
        .res          (res),
        .ram_wr       (ram_wr),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    wmcs_window_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_cost_reg <= res.cost;
        end
    end

endmodule

// ===== sv/wmcs_checker.sv =====
// Port-level checker of the stop-selection core and its bind statement.
`timescale 1ns / 1ps
`include "windowed_min_cost_stop_dp_core_defines.svh"
module wmcs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [wmcs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [wmcs_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wmcs_pkg::M_TDATA_W-1:0] m_tdata
);
    import wmcs_pkg::*;

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;

    // A stalled result keeps its value until the transfer.
    `WMCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "unstable")
    // Each item is worked on alone: no second transfer right after one.
    `WMCS_ASSERT_NEXT(a_one_item, in_xfer, !s_tready, "input ready right after a transfer")
    // A fresh result appears only at the end of an item's work.
    `WMCS_ASSERT(a_rose_busy, $rose(m_tvalid) |-> !$past(s_tready), "result without work")
    // Padding bits above best_cost stay zero.
    `WMCS_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[M_TDATA_W-1:COST_W] == '0), "padding set")

endmodule

bind windowed_min_cost_stop_dp_core wmcs_checker u_wmcs_checker (.*);

// ===== test/windowed_min_cost_stop_dp_core_test.sv =====
// Self-checking testbench of the windowed minimum-cost stop-selection core.
`timescale 1ns / 1ps
module windowed_min_cost_stop_dp_core_test;
    import wmcs_pkg::*;

    localparam int PHASE_ITEMS = 110;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [STOP_W-1:0] STOP_MAX = {STOP_W{1'b1}};

    typedef struct {
        bit                is_gap;
        logic [GAP_W-1:0]  gap;
        logic [STOP_W-1:0] cost;
        bit                must_stop;
        bit                restart;
        bit                known;
        logic [COST_W-1:0] want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // stop_cost
    logic [S_TUSER_W-1:0] s_tuser = '0;   // mandatory, first
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // best_cost
    logic                 cfg_wr_en = 1'b0;
    logic [GAP_W-1:0]     cfg_wr_data = '0;

    // Predictor state: candidate costs, one place further back per entry.
    logic [COST_W-1:0] cand_cost [WINDOW_DEPTH];
    bit                cand_live [WINDOW_DEPTH];
    logic [GAP_W-1:0]  gap_setting = GAP_W'(1);

    logic [COST_W-1:0] pending_cost [$];
    plan_row_t         directed [$];
    bit                stall_on = 1'b1;
    int                rx_hold = 0;
    int                quiet_cycles = 0;
    int                failures = 0;
    int                stations_sent = 0;
    int                results_seen = 0;
    int                route_starts = 0;
    int                mandatory_stops = 0;
    int                saturated = 0;
    int                gap_writes = 0;

    windowed_min_cost_stop_dp_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic int lane_span();
        if (gap_setting == '0) begin
            return 1;
        end
        if (int'(gap_setting) > WINDOW_DEPTH) begin
            return WINDOW_DEPTH;
        end
        return int'(gap_setting);
    endfunction

    function automatic logic [COST_W-1:0] next_best_cost(input logic [STOP_W-1:0] cost,
                                                         input bit must_stop,
                                                         input bit restart);
        int d;
        int span;
        bit found;
        logic [COST_W-1:0] best;
        logic [COST_W:0] total;
        logic [COST_W-1:0] outcome;
        span = lane_span();
        found = 1'b0;
        best = COST_MAX;
        if (restart) begin
            for (d = 0; d < WINDOW_DEPTH; d++) begin
                cand_live[d] = 1'b0;
            end
            cand_cost[0] = '0;
            cand_live[0] = 1'b1;
        end
        for (d = 0; d < span; d++) begin
            if (cand_live[d] && (!found || cand_cost[d] < best)) begin
                best = cand_cost[d];
                found = 1'b1;
            end
        end
        total = {1'b0, best} + (COST_W + 1)'(cost);
        if (!found || total > {1'b0, COST_MAX}) begin
            outcome = COST_MAX;
        end else begin
            outcome = total[COST_W-1:0];
        end
        // A mandatory stop hides everything before it from later stations.
        if (must_stop) begin
            for (d = 0; d < WINDOW_DEPTH; d++) begin
                cand_live[d] = 1'b0;
            end
        end
        for (d = WINDOW_DEPTH - 1; d > 0; d--) begin
            cand_cost[d] = cand_cost[d-1];
            cand_live[d] = cand_live[d-1];
        end
        cand_cost[0] = outcome;
        cand_live[0] = 1'b1;
        return outcome;
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pick_pause();
        int r;
        if (!stall_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [STOP_W-1:0] random_cost();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return STOP_MAX;
        end else if (r < 5) begin
            return STOP_W'($urandom_range(0, 31));
        end else if (r < 7) begin
            return STOP_W'($urandom_range(0, 1023));
        end
        return STOP_W'($urandom);
    endfunction

    function automatic plan_row_t station_row(input logic [STOP_W-1:0] cost, input bit must_stop,
                                              input bit restart, input bit known,
                                              input logic [COST_W-1:0] want);
        plan_row_t row;
        row.is_gap = 1'b0;
        row.gap = '0;
        row.cost = cost;
        row.must_stop = must_stop;
        row.restart = restart;
        row.known = known;
        row.want = want;
        return row;
    endfunction

    function automatic plan_row_t gap_row(input logic [GAP_W-1:0] gap);
        plan_row_t row;
        row = station_row('0, 1'b0, 1'b0, 1'b0, '0);
        row.is_gap = 1'b1;
        row.gap = gap;
        return row;
    endfunction

    task automatic send_station(input logic [STOP_W-1:0] cost, input bit must_stop,
                                input bit restart, input bit known,
                                input logic [COST_W-1:0] want);
        int idle;
        logic [COST_W-1:0] predicted;
        idle = pick_pause();
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(cost);
        s_tuser <= {restart, must_stop};
        do @(posedge aclk); while (!s_tready);
        predicted = next_best_cost(cost, must_stop, restart);
        pending_cost.push_back(known ? want : predicted);
        stations_sent++;
        route_starts += restart;
        mandatory_stops += must_stop;
        saturated += (predicted == COST_MAX);
    endtask

    // Lets every expected result come out, then a pause of about one latency.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_cost.size() != 0) @(posedge aclk);
        repeat (lane_span() + 4) @(posedge aclk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] gap);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= gap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gap_setting = gap;
        gap_writes++;
    endtask

    always @(posedge aclk) begin : result_check
        logic [COST_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_cost.size() == 0) begin
                $error("best_cost: expected nothing, actual %0d", m_tdata[COST_W-1:0]);
                failures++;
            end else begin
                want = pending_cost.pop_front();
                if (m_tdata[COST_W-1:0] !== want) begin
                    $error("best_cost: expected %0d, actual %0d", want, m_tdata[COST_W-1:0]);
                    failures++;
                end
            end
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold = pick_pause();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int phase_gaps [11];
        int p;
        int k;
        int sent;
        int route_len;
        phase_gaps = '{3, 1, 64, 0, 127, 17, 2, 65, 33, 8, 0};
        for (p = 0; p < WINDOW_DEPTH; p++) begin
            cand_cost[p] = '0;
            cand_live[p] = 1'b0;
        end

        // With no route started yet, every result is saturated.
        directed.push_back(station_row(30'd7, 1'b0, 1'b0, 1'b1, COST_MAX));
        directed.push_back(station_row(30'd0, 1'b0, 1'b0, 1'b1, COST_MAX));
        directed.push_back(station_row(STOP_MAX, 1'b1, 1'b0, 1'b1, COST_MAX));
        directed.push_back(station_row(30'd5, 1'b0, 1'b1, 1'b1, COST_W'(5)));
        directed.push_back(station_row(STOP_MAX, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd0, 1'b1, 1'b1, 1'b1, '0));
        directed.push_back(gap_row(GAP_W'(0)));
        directed.push_back(station_row(30'd3, 1'b1, 1'b1, 1'b1, COST_W'(3)));
        directed.push_back(station_row(30'd4, 1'b0, 1'b0, 1'b1, COST_W'(7)));
        directed.push_back(gap_row(GAP_W'(127)));
        directed.push_back(station_row(30'd100, 1'b0, 1'b1, 1'b1, COST_W'(100)));
        directed.push_back(station_row(30'd1, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd10, 1'b1, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd2, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(STOP_MAX, 1'b1, 1'b1, 1'b1, COST_W'(STOP_MAX)));
        directed.push_back(gap_row(GAP_W'(64)));
        directed.push_back(station_row(30'd20, 1'b0, 1'b1, 1'b1, COST_W'(20)));
        directed.push_back(station_row(30'd30, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd1, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(STOP_MAX, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(gap_row(GAP_W'(65)));
        directed.push_back(station_row(30'd8, 1'b0, 1'b1, 1'b1, COST_W'(8)));
        directed.push_back(station_row(30'd9, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(gap_row(GAP_W'(2)));
        directed.push_back(station_row(30'd50, 1'b0, 1'b1, 1'b1, COST_W'(50)));
        directed.push_back(station_row(30'd60, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd70, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd0, 1'b1, 1'b0, 1'b0, '0));
        directed.push_back(station_row(30'd0, 1'b0, 1'b0, 1'b0, '0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_gap) begin
                write_gap(directed[i].gap);
            end else begin
                send_station(directed[i].cost, directed[i].must_stop, directed[i].restart,
                             directed[i].known, directed[i].want);
            end
        end

        // Random phases: mostly whole routes with random content, some stray stations.
        for (p = 0; p < 11; p++) begin
            stall_on = ($urandom_range(0, 3) != 0);
            write_gap((p == 10) ? GAP_W'($urandom_range(0, 127)) : GAP_W'(phase_gaps[p]));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_station(random_cost(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end else begin
                    route_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
                                                            : $urandom_range(1, 30);
                    for (k = 0; k < route_len && sent < PHASE_ITEMS; k++) begin
                        send_station(random_cost(), $urandom_range(0, 7) == 0, k == 0,
                                     1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        settle_block();
        $display("%0d stations, %0d results checked, %0d gap writes", stations_sent,
                 results_seen, gap_writes);
        $display("%0d route starts, %0d mandatory stops, %0d saturated results",
                 route_starts, mandatory_stops, saturated);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wmcs_pkg.sv
sv/wmcs_window_ram.sv
sv/wmcs_ctrl.sv
sv/windowed_min_cost_stop_dp_core.sv
sv/wmcs_checker.sv
test/windowed_min_cost_stop_dp_core_test.sv
